// ===== rtl/sponge_hash_176bit_permutation_core_macros.svh =====
// Assertion macros for the sponge hash core.
// Depends on nothing; included by the top level.
`ifndef SPONGE_HASH_176BIT_PERMUTATION_CORE_MACROS_SVH
`define SPONGE_HASH_176BIT_PERMUTATION_CORE_MACROS_SVH
`ifndef SYNTH
`define SH_ASSERT_IMP(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("sponge hash assertion failed");
`define SH_ASSERT_NXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("sponge hash assertion failed");
`else
`define SH_ASSERT_IMP(lbl, clk, rstn, pre, post)
`define SH_ASSERT_NXT(lbl, clk, rstn, pre, post)
`endif
`endif

// ===== rtl/sh176_pkg.sv =====
// Types, constants and round function of the 176-bit sponge hash.
// No dependencies; used by the controller, datapath and top level.
package sh176_pkg;

    localparam int STATE_BITS = 176;
    localparam int MAX_DIGEST = 64;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [1:0] ABS_NONE     = 2'd0;
    localparam logic [1:0] ABS_MSG      = 2'd1;
    localparam logic [1:0] ABS_PAD_HELD = 2'd2;
    localparam logic [1:0] ABS_PAD_ONLY = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       msg_last;
    } sh_in_t;

    typedef struct packed {
        logic [7:0] digest_byte;
        logic       digest_last;
    } sh_out_t;

    typedef struct packed {
        logic       hold;
        logic [1:0] absorb_sel;
        logic       lfsr_load;
        logic       round;
        logic       clear;
        logic       out_load;
        logic       out_sel;
        logic       out_last;
    } dp_cmd_t;

    localparam logic [3:0] SBOX [16] = '{
        4'hE, 4'hD, 4'hB, 4'h0, 4'h2, 4'h1, 4'h4, 4'hF,
        4'h7, 4'hA, 4'h8, 4'h5, 4'h9, 4'hC, 4'h3, 4'h6
    };

    function automatic logic [6:0] lfsr_step(input logic [6:0] v);
        lfsr_step = {v[5:0], v[6] ^ v[5]};
    endfunction

    function automatic logic [STATE_BITS-1:0] round_f(input logic [STATE_BITS-1:0] s,
                                                      input logic [6:0] lfsr);
        logic [STATE_BITS-1:0] x;
        logic [STATE_BITS-1:0] p;
        logic [7:0]            rev;
        x = s;
        for (int k = 0; k < 8; k++) begin
            rev[7-k] = (k < 7) ? lfsr[k] : 1'b0;
        end
        x[7:0]     = x[7:0] ^ {1'b0, lfsr};
        x[175:168] = x[175:168] ^ rev;
        for (int n = 0; n < STATE_BITS / 4; n++) begin
            x[n*4 +: 4] = SBOX[x[n*4 +: 4]];
        end
        p = '0;
        for (int i = 0; i < STATE_BITS - 1; i++) begin
            p[(i * (STATE_BITS / 4)) % (STATE_BITS - 1)] = x[i];
        end
        p[STATE_BITS-1] = x[STATE_BITS-1];
        round_f = p;
    endfunction

endpackage

// ===== rtl/sh176_datapath.sv =====
// Datapath: sponge state, held byte, round LFSR and digest output register.
// Depends on sh176_pkg; driven by sh176_ctrl commands.
module sh176_datapath import sh176_pkg::*; #(
    parameter int unsigned LFSR_INIT = 69
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] in_byte,
    input  dp_cmd_t    cmd,
    output sh_out_t    out_data
);

    logic [STATE_BITS-1:0] state_reg, state_next;
    logic [7:0]            held_reg;
    logic [6:0]            lfsr_reg;
    sh_out_t               out_reg;

    always_comb begin
        state_next = state_reg;
        case (cmd.absorb_sel)
            ABS_MSG:      state_next[15:0] = state_reg[15:0] ^ {in_byte, held_reg};
            ABS_PAD_HELD: state_next[15:0] = state_reg[15:0] ^ {PAD_BYTE, held_reg};
            ABS_PAD_ONLY: state_next[15:0] = state_reg[15:0] ^ {8'h00, PAD_BYTE};
            default:      state_next = state_reg;
        endcase
        if (cmd.round) begin
            state_next = round_f(state_reg, lfsr_reg);
        end
        if (cmd.clear) begin
            state_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
            held_reg  <= '0;
            lfsr_reg  <= 7'(LFSR_INIT);
            out_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (cmd.hold) begin
                held_reg <= in_byte;
            end
            if (cmd.lfsr_load) begin
                lfsr_reg <= 7'(LFSR_INIT);
            end else if (cmd.round) begin
                lfsr_reg <= lfsr_step(lfsr_reg);
            end
            if (cmd.out_load) begin
                out_reg.digest_byte <= cmd.out_sel ? state_reg[15:8] : state_reg[7:0];
                out_reg.digest_last <= cmd.out_last;
            end
        end
    end

    assign out_data = out_reg;

endmodule

// ===== rtl/sh176_ctrl.sv =====
// Controller: absorb/pad/permute/squeeze sequencing, handshakes, digest length.
// Depends on sh176_pkg; commands sh176_datapath.
module sh176_ctrl import sh176_pkg::*; #(
    parameter int unsigned ROUNDS = 90
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [6:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  sh_in_t     s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output dp_cmd_t    cmd
);

    localparam int RND_W = $clog2(ROUNDS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PAD  = 2'd1;
    localparam logic [1:0] ST_PERM = 2'd2;
    localparam logic [1:0] ST_SQZ  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [RND_W-1:0] rnd_reg, rnd_next;
    logic             half_reg, half_next;
    logic             pend_last_reg, pend_last_next;
    logic             sqz_reg, sqz_next;
    logic [6:0]       cnt_reg, cnt_next;
    logic             kidx_reg, kidx_next;
    logic             m_valid_reg, m_valid_next;
    logic [6:0]       dlen_reg;
    logic [6:0]       total;
    logic             accept;
    logic             out_free;

    assign total    = (dlen_reg > 7'(MAX_DIGEST)) ? 7'(MAX_DIGEST) : dlen_reg;
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next     = state_reg;
        rnd_next       = rnd_reg;
        half_next      = half_reg;
        pend_last_next = pend_last_reg;
        sqz_next       = sqz_reg;
        cnt_next       = cnt_reg;
        kidx_next      = kidx_reg;
        m_valid_next   = (m_valid_reg && m_ready) ? 1'b0 : m_valid_reg;
        cmd            = '0;
        cmd.absorb_sel = ABS_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.byte_present && half_reg) begin
                        cmd.absorb_sel = ABS_MSG;
                        cmd.lfsr_load  = 1'b1;
                        half_next      = 1'b0;
                        pend_last_next = s_data.msg_last;
                        sqz_next       = 1'b0;
                        rnd_next       = '0;
                        state_next     = ST_PERM;
                    end else begin
                        if (s_data.byte_present) begin
                            cmd.hold  = 1'b1;
                            half_next = 1'b1;
                        end
                        if (s_data.msg_last) begin
                            state_next = ST_PAD;
                        end
                    end
                end
            end
            ST_PAD: begin
                cmd.absorb_sel = half_reg ? ABS_PAD_HELD : ABS_PAD_ONLY;
                cmd.lfsr_load  = 1'b1;
                half_next      = 1'b0;
                sqz_next       = 1'b1;
                cnt_next       = '0;
                kidx_next      = 1'b0;
                rnd_next       = '0;
                state_next     = ST_PERM;
            end
            ST_PERM: begin
                cmd.round = 1'b1;
                rnd_next  = rnd_reg + 1'b1;
                if (rnd_reg == RND_W'(ROUNDS - 1)) begin
                    if (sqz_reg) begin
                        state_next = ST_SQZ;
                    end else if (pend_last_reg) begin
                        state_next = ST_PAD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SQZ: begin
                if (cnt_reg == total) begin
                    // zero-length digest
                    cmd.clear  = 1'b1;
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = kidx_reg;
                    cmd.out_last = (7'(cnt_reg + 7'd1) == total);
                    m_valid_next = 1'b1;
                    cnt_next     = cnt_reg + 7'd1;
                    if (7'(cnt_reg + 7'd1) == total) begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end else if (kidx_reg) begin
                        cmd.lfsr_load = 1'b1;
                        rnd_next      = '0;
                        kidx_next     = 1'b0;
                        state_next    = ST_PERM;
                    end else begin
                        kidx_next = 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            rnd_reg       <= '0;
            half_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            sqz_reg       <= 1'b0;
            cnt_reg       <= '0;
            kidx_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
            dlen_reg      <= 7'd20;
        end else begin
            state_reg     <= state_next;
            rnd_reg       <= rnd_next;
            half_reg      <= half_next;
            pend_last_reg <= pend_last_next;
            sqz_reg       <= sqz_next;
            cnt_reg       <= cnt_next;
            kidx_reg      <= kidx_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_wr_en) begin
                dlen_reg <= cfg_wr_data;
            end
        end
    end

endmodule

// ===== rtl/sponge_hash_176bit_permutation_core.sv =====
// Sponge hash, 176-bit state, 16-bit rate. One round per cycle.
// A byte completing a block starts a permutation, with s_ready low until it ends; an odd byte is held.
// Last transaction: padding and a permutation (after a pending completed block's permutation) come
// before the first digest byte; two bytes per block, with a permutation between blocks, plus stalls.
// Reset (aresetn, sync, active low): controller idle, sponge state zero, digest_len 20.
`include "sponge_hash_176bit_permutation_core_macros.svh"
module sponge_hash_176bit_permutation_core import sh176_pkg::*; #(
    parameter int unsigned ROUNDS    = 90,
    parameter int unsigned LFSR_INIT = 69
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [6:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  sh_in_t     s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output sh_out_t    m_data
);

    dp_cmd_t dp_cmd;

    sh176_ctrl #(
        .ROUNDS(ROUNDS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .cmd        (dp_cmd)
    );

    sh176_datapath #(
        .LFSR_INIT(LFSR_INIT)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_byte (s_data.data_byte),
        .cmd     (dp_cmd),
        .out_data(m_data)
    );

    `SH_ASSERT_IMP(a_no_round_when_ready, aclk, aresetn, s_ready, !dp_cmd.round)
    `SH_ASSERT_NXT(a_load_sets_valid, aclk, aresetn, dp_cmd.out_load, m_valid)
    `SH_ASSERT_IMP(a_last_clears, aclk, aresetn, dp_cmd.out_load && dp_cmd.out_last, dp_cmd.clear)

endmodule

// ===== dv/sponge_hash_176bit_permutation_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sponge_hash_176bit_permutation_core: directed and random messages,
// every digest byte checked against an in-bench sponge model. Needs sh176_pkg and the core RTL.
module sponge_hash_176bit_permutation_core_tb;
    import sh176_pkg::*;

    localparam int         ROUNDS        = 90;
    localparam logic [6:0] RC_INIT       = 7'd69;
    localparam int         TARGET_ITEMS  = 130;
    localparam int         SETTLE_CYCLES = 400;
    localparam int         MAX_PRINTS    = 50;
    // S-box, entry 0 in the low nibble
    localparam logic [63:0] SUB_TABLE    = 64'h63C958A7F4120BDE;

    typedef struct {
        sh_in_t txn;
        bit     hold_off;
    } queued_txn_t;

    typedef enum int {RX_STREAM, RX_CHOPPY, RX_STARVED} rx_mode_t;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic [6:0] cfg_wr_data = '0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    sh_in_t     s_data      = '0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    sh_out_t    m_data;

    queued_txn_t  send_q[$];
    sh_out_t      digest_q[$];
    logic [175:0] sponge     = '0;
    logic [7:0]   held       = '0;
    bit           held_valid = 1'b0;
    logic [6:0]   digest_cfg = 7'd20;

    int pushed_total   = 0;
    int accepted_total = 0;
    int items_queued   = 0;
    int msg_count      = 0;
    int bytes_checked  = 0;
    int error_count    = 0;

    int          burst_left = 0;
    int          gap_left   = 0;
    queued_txn_t cur;
    rx_mode_t    rx_mode    = RX_STREAM;
    int          mode_left  = 0;
    sh_out_t     want;

    sponge_hash_176bit_permutation_core dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    always #1 aclk = ~aclk;

    function automatic logic [175:0] sponge_round(input logic [175:0] s, input logic [6:0] rc);
        logic [175:0] t;
        logic [175:0] p;
        t = s;
        t[6:0] = t[6:0] ^ rc;
        // bit-reversed constant lands in the top byte, its low bit stays clear
        for (int k = 0; k < 7; k++) t[175 - k] = t[175 - k] ^ rc[k];
        for (int n = 0; n < 44; n++) t[4*n +: 4] = SUB_TABLE[int'(t[4*n +: 4]) * 4 +: 4];
        p = '0;
        for (int i = 0; i < 175; i++) p[(i * 44) % 175] = t[i];
        p[175] = t[175];
        return p;
    endfunction

    function automatic void run_permutation();
        logic [6:0] rc;
        rc = RC_INIT;
        for (int r = 0; r < ROUNDS; r++) begin
            sponge = sponge_round(sponge, rc);
            rc = {rc[5:0], rc[6] ^ rc[5]};
        end
    endfunction

    function automatic void hash_transaction(input sh_in_t t);
        sh_out_t d;
        int      total;
        int      n;
        if (t.byte_present) begin
            if (!held_valid) begin
                held = t.data_byte;
                held_valid = 1'b1;
            end else begin
                sponge[7:0]  = sponge[7:0] ^ held;
                sponge[15:8] = sponge[15:8] ^ t.data_byte;
                held = '0;
                held_valid = 1'b0;
                run_permutation();
            end
        end
        if (!t.msg_last) return;
        if (held_valid) begin
            sponge[7:0]  = sponge[7:0] ^ held;
            sponge[15:8] = sponge[15:8] ^ PAD_BYTE;
        end else begin
            sponge[7:0] = sponge[7:0] ^ PAD_BYTE;
        end
        run_permutation();
        total = (digest_cfg > MAX_DIGEST) ? MAX_DIGEST : int'(digest_cfg);
        n = 0;
        while (n < total) begin
            for (int k = 0; k < 2 && n < total; k++) begin
                d.digest_byte = sponge[8*k +: 8];
                d.digest_last = (n + 1 == total);
                digest_q.push_back(d);
                n++;
            end
            if (n < total) run_permutation();
        end
        sponge = '0;
        held = '0;
        held_valid = 1'b0;
    endfunction

    function automatic void queue_txn(input logic [7:0] b, input bit present, input bit last,
                                      input bit hold);
        queued_txn_t e;
        e.txn.data_byte    = b;
        e.txn.byte_present = present;
        e.txn.msg_last     = last;
        e.hold_off         = hold;
        send_q.push_back(e);
        pushed_total++;
        if (present || last) items_queued++;
        if (last) msg_count++;
    endfunction

    function automatic void queue_message(input int len, input bit hold);
        bit last_carries;
        last_carries = (len > 0) && bit'($urandom_range(0, 1));
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 7) == 0)
                queue_txn(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
            queue_txn(8'($urandom_range(0, 255)), 1'b1, last_carries && i == len - 1,
                      hold && i == 0);
        end
        if (!last_carries)
            queue_txn(8'($urandom_range(0, 255)), 1'b0, 1'b1, hold && len == 0);
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTS) $display("[%0t] MISMATCH: %s", $time, msg);
        error_count++;
    endtask

    task automatic wait_drained();
        while (accepted_total != pushed_total || digest_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_digest_len(input logic [6:0] v);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        digest_cfg = v;
    endtask

    // sender: bursts of transactions separated by random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                hash_transaction(s_data);
                accepted_total++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (send_q.size() != 0 &&
                             !(send_q[0].hold_off && digest_q.size() != 0)) begin
                    cur = send_q.pop_front();
                    s_data  <= cur.txn;
                    s_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 8);
                        case ($urandom_range(0, 7))
                            0, 1, 2: gap_left = 0;
                            7:       gap_left = $urandom_range(20, 200);
                            default: gap_left = $urandom_range(1, 6);
                        endcase
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_mode = RX_STREAM;
            mode_left = 0;
        end else begin
            if (mode_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(20, 120);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                RX_STREAM:  m_ready <= 1'b1;
                RX_CHOPPY:  m_ready <= bit'($urandom_range(0, 1));
                default:    m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (digest_q.size() == 0) begin
                report_mismatch($sformatf("unexpected digest byte %02h last %0b",
                                          m_data.digest_byte, m_data.digest_last));
            end else begin
                want = digest_q.pop_front();
                if (m_data.digest_byte !== want.digest_byte)
                    report_mismatch($sformatf("digest_byte %02h, want %02h",
                                              m_data.digest_byte, want.digest_byte));
                if (m_data.digest_last !== want.digest_last)
                    report_mismatch($sformatf("digest_last %0b, want %0b",
                                              m_data.digest_last, want.digest_last));
                bytes_checked++;
            end
        end
    end

    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // default length: empty message, odd/even lengths, pad with and without held byte
        queue_txn(8'h3C, 1'b0, 1'b1, 1'b0);
        queue_txn(8'h00, 1'b1, 1'b1, 1'b0);
        queue_txn(8'hFF, 1'b1, 1'b0, 1'b0);
        queue_txn(8'hFF, 1'b1, 1'b1, 1'b0);
        queue_txn(8'hA5, 1'b0, 1'b0, 1'b0);
        queue_txn(8'h01, 1'b1, 1'b0, 1'b0);
        queue_txn(8'h80, 1'b1, 1'b0, 1'b0);
        queue_txn(8'h5A, 1'b0, 1'b1, 1'b0);
        queue_txn(8'h7F, 1'b1, 1'b0, 1'b1);
        queue_txn(8'h80, 1'b1, 1'b0, 1'b0);
        queue_txn(8'h55, 1'b0, 1'b1, 1'b0);

        set_digest_len(7'd1);
        queue_txn(8'hC3, 1'b1, 1'b1, 1'b0);
        queue_txn(8'h00, 1'b0, 1'b1, 1'b0);

        set_digest_len(7'd64);
        queue_txn(8'h12, 1'b1, 1'b0, 1'b0);
        queue_txn(8'h34, 1'b1, 1'b1, 1'b0);

        // zero length: message completes silently
        set_digest_len(7'd0);
        queue_txn(8'hAA, 1'b1, 1'b0, 1'b0);
        queue_txn(8'hBB, 1'b1, 1'b1, 1'b0);
        queue_txn(8'hCC, 1'b1, 1'b1, 1'b0);

        // saturates at 64
        set_digest_len(7'd127);
        queue_txn(8'hFF, 1'b1, 1'b0, 1'b0);
        queue_txn(8'h00, 1'b0, 1'b1, 1'b0);

        while (items_queued < TARGET_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       set_digest_len(7'd0);
                1:       set_digest_len(7'($urandom_range(65, 127)));
                2:       set_digest_len(7'd1);
                default: set_digest_len(7'($urandom_range(1, 64)));
            endcase
            repeat ($urandom_range(2, 4))
                queue_message(($urandom_range(0, 4) == 0) ? $urandom_range(5, 14)
                                                          : $urandom_range(0, 4),
                              $urandom_range(0, 5) == 0);
        end

        wait_drained();
        $display("Covered %0d messages in %0d transactions; %0d digest bytes checked.",
                 msg_count, accepted_total, bytes_checked);
        $display("Digest lengths from zero to saturation, with sender gaps and receiver stalls.");
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
